// File: sv/rlec_pkg.sv
// rlec_pkg: shared types and constants for the multi-mode run-length decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rlec_pkg;

   localparam logic [1:0] MODE_PAIR = 2'd0;
   localparam logic [1:0] MODE_ESC  = 2'd1;
   localparam logic [1:0] MODE_FLAG = 2'd2;
   localparam logic [1:0] MODE_BITS = 2'd3;

   localparam logic [1:0] ST_RUN    = 2'd0;
   localparam logic [1:0] ST_END    = 2'd1;
   localparam logic [1:0] ST_TRUNC  = 2'd2;
   localparam logic [1:0] ST_PREFIX = 2'd3;

   localparam logic REG_MODE   = 1'b0;
   localparam logic REG_ESCAPE = 1'b1;

   localparam logic [7:0] TOP_BIT  = 8'h80;
   localparam logic [7:0] LOW_MASK = 8'h7f;

   typedef enum logic [2:0] {
      PH_FIRST  = 3'b001,
      PH_SECOND = 3'b010,
      PH_THIRD  = 3'b100
   } parse_phase_type;

   typedef enum logic [2:0] {
      BP_PREFIX = 3'b001,
      BP_LEN    = 3'b010,
      BP_CODE   = 3'b100
   } bit_phase_type;

   // bit-level parser state for the unary-prefixed mode
   typedef struct packed {
      bit_phase_type phase;
      logic [4:0]    prefix;
      logic [5:0]    bidx;
      logic [15:0]   len;
      logic [7:0]    code;
   } bits_state_type;

   // one queued beat, classified by the front
   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_end;
      logic       is_escape;
   } item_type;

endpackage

// File: sv/rlec_front.sv
// rlec_front: accepts input beats, tags escape bytes, holds them in a two-entry queue
// depends on rlec_pkg
`timescale 1ns / 1ps

module rlec_front import rlec_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_stream_end,
   input  logic [7:0] escape_value,
   output logic       q_valid,
   input  logic       q_ready,
   output item_type   q_item
);

   item_type   q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = q_ff[rptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff].in_byte    <= req_in_byte;
         q_ff[wptr_ff].stream_end <= req_stream_end;
         q_ff[wptr_ff].is_escape  <= (req_in_byte == escape_value);
      end
   end

endmodule

// File: sv/rlec_back.sv
// rlec_back: decodes queued beats per mode and holds the result register
// depends on rlec_pkg; fed by rlec_front
`timescale 1ns / 1ps

module rlec_back import rlec_pkg::*; #(
   parameter int MAX_PREFIX = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  mode,
   input  logic        restart,
   input  logic        q_valid,
   output logic        q_ready,
   input  item_type    q_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_run_value,
   output logic [16:0] rsp_run_count,
   output logic [1:0]  rsp_status
);

   parse_phase_type phase_ff, phase_in;
   logic [7:0]      held_ff, held_in;
   logic [2:0]      hdr_ff, hdr_in;
   logic [31:0]     total_ff, total_in;
   logic [32:0]     produced_ff, produced_in;
   logic            finished_ff, finished_in;
   logic            err_ff, err_in;
   bits_state_type  bs_ff, bs_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      value_ff, value_in;
   logic [16:0]     count_ff, count_in;
   logic [1:0]      status_ff, status_in;

   logic            load, emit, have_run, err_now, run_hit, stop, bit_v;
   logic [7:0]      rv;
   logic [16:0]     rc;
   logic [33:0]     sum;
   bits_state_type  bs, bs_run;

   assign q_ready       = !rsp_valid_ff || rsp_ready;
   assign load          = q_valid && q_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_run_value = value_ff;
   assign rsp_run_count = count_ff;
   assign rsp_status    = status_ff;

   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      hdr_in      = hdr_ff;
      total_in    = total_ff;
      produced_in = produced_ff;
      finished_in = finished_ff;
      err_in      = err_ff;
      bs_in       = bs_ff;
      have_run    = 1'b0;
      err_now     = 1'b0;
      run_hit     = 1'b0;
      stop        = 1'b0;
      bit_v       = 1'b0;
      rv          = 8'd0;
      rc          = 17'd0;
      sum         = 34'd0;
      bs          = bs_ff;
      bs_run      = bs_ff;
      emit        = 1'b0;
      status_in   = ST_RUN;

      case (mode)
         MODE_PAIR: begin
            if (phase_ff == PH_FIRST) begin
               held_in  = q_item.in_byte;
               phase_in = PH_SECOND;
            end else begin
               phase_in = PH_FIRST;
               if (held_ff != 8'd0) begin
                  have_run = 1'b1;
                  rv       = q_item.in_byte;
                  rc       = {9'd0, held_ff};
               end
            end
         end
         MODE_ESC, MODE_FLAG: begin
            if (phase_ff == PH_FIRST) begin
               if (mode == MODE_ESC && q_item.is_escape) begin
                  phase_in = PH_SECOND;
               end else if (mode == MODE_FLAG && (q_item.in_byte & TOP_BIT) != 8'd0) begin
                  held_in  = q_item.in_byte & LOW_MASK;
                  phase_in = PH_THIRD;
               end else begin
                  have_run = 1'b1;
                  rv       = q_item.in_byte;
                  rc       = 17'd1;
               end
            end else if (phase_ff == PH_SECOND) begin
               held_in  = q_item.in_byte;
               phase_in = PH_THIRD;
            end else begin
               phase_in = PH_FIRST;
               if (held_ff != 8'd0) begin
                  have_run = 1'b1;
                  rv       = q_item.in_byte;
                  rc       = {9'd0, held_ff};
               end
            end
         end
         MODE_BITS: begin
            if (!err_ff && !finished_ff) begin
               if (hdr_ff != 3'd4) begin
                  total_in = {total_ff[23:0], q_item.in_byte};
                  hdr_in   = hdr_ff + 3'd1;
                  if (hdr_ff == 3'd3 && {total_ff[23:0], q_item.in_byte} == 32'd0) begin
                     finished_in = 1'b1;
                  end
               end else begin
                  // msb-first walk of the eight bits; at most one record ends per byte
                  for (int b = 7; b >= 0; b--) begin
                     if (!stop) begin
                        bit_v = q_item.in_byte[b];
                        case (bs.phase)
                           BP_PREFIX: begin
                              if (bit_v) begin
                                 if (bs.prefix >= 5'(MAX_PREFIX)) begin
                                    err_now = 1'b1;
                                    stop    = 1'b1;
                                 end else begin
                                    bs.prefix = bs.prefix + 5'd1;
                                 end
                              end else begin
                                 bs.phase = BP_LEN;
                                 bs.bidx  = 6'd0;
                                 bs.len   = 16'd0;
                              end
                           end
                           BP_LEN: begin
                              if (bs.bidx < 6'd16) begin
                                 bs.len[bs.bidx[3:0]] = bit_v;
                              end
                              bs.bidx = bs.bidx + 6'd1;
                              if (bs.bidx >= {1'b0, bs.prefix} + 6'd2) begin
                                 bs.phase = BP_CODE;
                                 bs.bidx  = 6'd0;
                                 bs.code  = 8'd0;
                              end
                           end
                           default: begin
                              bs.code = {bs.code[6:0], bit_v};
                              bs.bidx = bs.bidx + 6'd1;
                              if (bs.bidx >= 6'd8) begin
                                 run_hit   = 1'b1;
                                 rv        = bs.code;
                                 rc        = {1'b0, bs.len} + 17'd1;
                                 bs.phase  = BP_PREFIX;
                                 bs.prefix = 5'd0;
                                 bs.bidx   = 6'd0;
                                 bs_run    = bs;
                              end
                           end
                        endcase
                     end
                  end
                  bs_in  = bs;
                  err_in = err_now;
                  if (run_hit) begin
                     have_run    = 1'b1;
                     sum         = {1'b0, produced_ff} + {17'd0, rc};
                     produced_in = sum[32:0];
                     // size reached: the rest of the byte is dropped
                     if (sum >= {2'b00, total_ff}) begin
                        finished_in = 1'b1;
                        err_now     = 1'b0;
                        err_in      = 1'b0;
                        bs_in       = bs_run;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (q_item.stream_end) begin
         emit = 1'b1;
         if (mode == MODE_BITS) begin
            if (err_ff || err_now) begin
               emit      = err_now;
               status_in = ST_PREFIX;
            end else begin
               status_in = finished_in ? ST_END : ST_TRUNC;
            end
         end else begin
            status_in = (phase_in == PH_FIRST) ? ST_END : ST_TRUNC;
         end
         phase_in    = PH_FIRST;
         held_in     = 8'd0;
         hdr_in      = 3'd0;
         total_in    = 32'd0;
         produced_in = 33'd0;
         finished_in = 1'b0;
         err_in      = 1'b0;
         bs_in       = '{phase: BP_PREFIX, prefix: 5'd0, bidx: 6'd0, len: 16'd0, code: 8'd0};
      end else if (err_now) begin
         emit      = 1'b1;
         status_in = ST_PREFIX;
      end else if (have_run) begin
         emit      = 1'b1;
         status_in = ST_RUN;
      end

      value_in     = have_run ? rv : 8'd0;
      count_in     = have_run ? rc : 17'd0;
      rsp_valid_in = load ? emit : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         phase_ff    <= PH_FIRST;
         held_ff     <= 8'd0;
         hdr_ff      <= 3'd0;
         total_ff    <= 32'd0;
         produced_ff <= 33'd0;
         finished_ff <= 1'b0;
         err_ff      <= 1'b0;
         bs_ff       <= '{phase: BP_PREFIX, prefix: 5'd0, bidx: 6'd0, len: 16'd0, code: 8'd0};
      end else if (load) begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         hdr_ff      <= hdr_in;
         total_ff    <= total_in;
         produced_ff <= produced_in;
         finished_ff <= finished_in;
         err_ff      <= err_in;
         bs_ff       <= bs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && emit) begin
         value_ff  <= value_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

endmodule

// File: sv/multi_mode_run_length_decoder.sv
// channel  | direction | ports
// req      | in        | req_valid, req_ready, req_in_byte, req_stream_end
// rsp      | out       | rsp_valid, rsp_ready, rsp_run_value, rsp_run_count, rsp_status
// csr      | in        | csr_we, csr_index, csr_wdata
//
// one beat per cycle sustained while rsp_ready stays high; an accepted beat is
// registered in the queue entry, then decoded into the result register
// the mode-3 eight-bit walk plus the size compare sets the back-end cycle
// synchronous active-high reset clears mode, escape byte and all stream state
// a two-entry queue lets the input run on while a result waits on rsp_ready
// top level: config registers, front queue and back decoder; uses rlec_pkg
`timescale 1ns / 1ps

module multi_mode_run_length_decoder import rlec_pkg::*; #(
   parameter int MAX_PREFIX = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_run_value,
   output logic [16:0] rsp_run_count,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [1:0] mode_ff, mode_in;
   logic [7:0] escape_ff, escape_in;
   logic       restart;
   logic       q_valid, q_ready;
   item_type   q_item;

   assign restart = csr_we && (csr_index == REG_MODE);

   always_comb begin
      mode_in   = restart ? csr_wdata[1:0] : mode_ff;
      escape_in = (csr_we && csr_index == REG_ESCAPE) ? csr_wdata : escape_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PAIR;
         escape_ff <= 8'd0;
      end else begin
         mode_ff   <= mode_in;
         escape_ff <= escape_in;
      end
   end

   rlec_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_stream_end (req_stream_end),
      .escape_value   (escape_ff),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_item         (q_item)
   );

   rlec_back #(.MAX_PREFIX(MAX_PREFIX)) u_back (
      .clock         (clock),
      .reset         (reset),
      .mode          (mode_ff),
      .restart       (restart),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_item        (q_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_run_value (rsp_run_value),
      .rsp_run_count (rsp_run_count),
      .rsp_status    (rsp_status)
   );

`ifndef SYNTHESIS
   // prefix errors only come out of the bitstream mode
   a_prefix_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_PREFIX |-> mode_ff == MODE_BITS)
      else $error("prefix error outside bitstream mode");

   // a plain run beat always carries a nonzero count
   a_run_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_RUN |-> rsp_run_count != 17'd0)
      else $error("run beat with zero count");

   // input stalls only when the queue holds work for the back end
   a_stall_queue: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("input stalled with empty queue");
`endif

endmodule
